// ===== sv/bsfh_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfh_pkg
// Types, register map and mixing functions of the byte stream hash unit.
// ----------------------------------------------------------------------------
package bsfh_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SEED_ADDR = 3'd0;

    // Request handed to the finishing pipeline at the end of a message
    typedef struct packed {
        logic [31:0] hash;
        logic [23:0] tail_bytes;
        logic [1:0]  tail_count;
        logic        zero;
    } fin_req_t;

    // Mix one group of four bytes; a group of all zeros leaves the hash alone
    function automatic logic [31:0] mix_block(input logic [31:0] h_in,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [31:0] h;
        logic [31:0] t;
        h = h_in;
        if ((lo != 16'h0) || (hi != 16'h0))
        begin
            h = h + {16'h0, lo};
            t = ({16'h0, hi} << 11) ^ h;
            h = (h << 16) ^ t;
            h = h + (h >> 11);
        end
        return h;
    endfunction

    // Fold in the one to three bytes left over at the end
    function automatic logic [31:0] tail_mix(input logic [31:0] h_in,
                                             input logic [23:0] tb,
                                             input logic [1:0]  n);
        logic [31:0] h;
        h = h_in;
        case (n)
            2'd3:
            begin
                h = h + {16'h0, tb[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({24'h0, tb[23:16]} << 18);
                h = h + (h >> 11);
            end
            2'd2:
            begin
                h = h + {16'h0, tb[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1:
            begin
                h = h + {24'h0, tb[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // First half of the avalanche
    function automatic logic [31:0] aval_a(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 2);
        h = h + (h >> 15);
        return h;
    endfunction

    // Second half of the avalanche, ending in the rotate-add
    function automatic logic [31:0] aval_b(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in ^ (h_in << 10);
        h = h + {h[15:0], h[31:16]};
        return h;
    endfunction

endpackage

// ===== sv/bsfh_finish.sv =====
// ----------------------------------------------------------------------------
// bsfh_finish
// Finishing pipeline: request register, tail mix, first avalanche half, second half into the result register.
// ----------------------------------------------------------------------------
module bsfh_finish
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsfh_pkg::fin_req_t in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_hash
);

    logic               a_valid_reg;
    bsfh_pkg::fin_req_t a_req_reg;
    logic               b_valid_reg;
    logic [31:0]        b_hash_reg;
    logic               b_zero_reg;
    logic               c_valid_reg;
    logic [31:0]        c_hash_reg;
    logic               c_zero_reg;
    logic               o_valid_reg;
    logic [31:0]        o_hash_reg;

    logic o_ready_in;
    logic c_ready_in;
    logic b_ready_in;
    logic a_ready_in;

    assign o_ready_in = !o_valid_reg || out_ready;
    assign c_ready_in = !c_valid_reg || o_ready_in;
    assign b_ready_in = !b_valid_reg || c_ready_in;
    assign a_ready_in = !a_valid_reg || b_ready_in;

    assign in_ready  = a_ready_in;
    assign out_valid = o_valid_reg;
    assign out_hash  = o_hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready_in)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready_in)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready_in)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready_in)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready_in && in_valid)
        begin
            a_req_reg <= in_req;
        end
        if (b_ready_in && a_valid_reg)
        begin
            b_hash_reg <= bsfh_pkg::tail_mix(a_req_reg.hash, a_req_reg.tail_bytes,
                                             a_req_reg.tail_count);
            b_zero_reg <= a_req_reg.zero;
        end
        if (c_ready_in && b_valid_reg)
        begin
            c_hash_reg <= bsfh_pkg::aval_a(b_hash_reg);
            c_zero_reg <= b_zero_reg;
        end
        if (o_ready_in && c_valid_reg)
        begin
            // an empty message hashes to zero
            o_hash_reg <= c_zero_reg ? 32'h0 : bsfh_pkg::aval_b(c_hash_reg);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready_in |=> a_valid_reg && $stable(a_req_reg))
        else $error("stage a lost or changed a stalled request");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted request did not reach stage a");

    o_load: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && o_ready_in |=> o_valid_reg)
        else $error("stage c result did not reach the output register");

    o_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && c_zero_reg && o_ready_in |=> o_hash_reg == 32'h0)
        else $error("empty message gave a nonzero hash");

endmodule

// ===== sv/byte_stream_fast_hash_32_unit.sv =====
// ----------------------------------------------------------------------------
// byte_stream_fast_hash_32_unit
// 32-bit byte stream hash: one message byte per word, hash emitted after tlast.
// ----------------------------------------------------------------------------
//  channel   dir  signals                              content
//  s_axis    in   s_tvalid s_tready s_tdata s_tlast     message byte, end mark,
//                 s_tuser                               empty message flag
//  m_axis    out  m_tvalid m_tready m_tdata             finished hash
//  apb       in   psel penable pwrite paddr pwdata      seed register at 0x0
//                 prdata pready
//
//  One byte is taken per cycle while s_tready is high; the mixing of a four-byte
//  group is done in the accepting cycle. A message whose tlast word is accepted
//  passes the request register, tail mix, first avalanche half, then the second
//  half into the output register, which holds its hash.
//  Reset clears the message state and the seed to zero.
//  A stall on m_axis fills the finishing pipeline, then drops s_tready.
module byte_stream_fast_hash_32_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,
    input  logic                        s_tuser,   // [0] empty_req
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] hash_value
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsfh_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0] seed_reg;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [23:0] bytes_reg;
    logic [23:0] bytes_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        in_msg_reg;

    logic               accept;
    logic               fin_ready;
    bsfh_pkg::fin_req_t fin_req;
    logic [31:0]        h_start;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == bsfh_pkg::REG_SEED_ADDR) ? seed_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'h0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr == bsfh_pkg::REG_SEED_ADDR))
        begin
            seed_reg <= pwdata;
        end
    end

    assign s_tready = fin_ready;
    assign accept   = s_tvalid && s_tready;

    // the first byte of a message starts from the seed
    assign h_start = in_msg_reg ? hash_reg : seed_reg;

    always_comb
    begin
        bytes_next = bytes_reg;
        hash_next  = h_start;
        count_next = count_reg + 2'd1;
        case (count_reg)
            2'd0:
            begin
                bytes_next[7:0] = s_tdata;
            end
            2'd1:
            begin
                bytes_next[15:8] = s_tdata;
            end
            2'd2:
            begin
                bytes_next[23:16] = s_tdata;
            end
            default:
            begin
                hash_next = bsfh_pkg::mix_block(h_start, bytes_reg[15:0],
                                                {s_tdata, bytes_reg[23:16]});
            end
        endcase
    end

    always_comb
    begin
        fin_req.hash       = hash_next;
        fin_req.tail_bytes = bytes_next;
        fin_req.tail_count = count_next;
        fin_req.zero       = s_tuser;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            in_msg_reg <= 1'b0;
        end
        else if (accept && (s_tlast || !s_tuser))
        begin
            if (s_tlast)
            begin
                count_reg  <= 2'd0;
                in_msg_reg <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                in_msg_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !s_tuser && !s_tlast)
        begin
            hash_reg  <= hash_next;
            bytes_reg <= bytes_next;
        end
    end

    bsfh_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && s_tlast),
        .in_ready  (fin_ready),
        .in_req    (fin_req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (m_tdata)
    );

endmodule
